@@ hw/rtl/pstk_pkg.sv @@
// ----------------------------------------------------------------------------
// pstk_pkg: shared types and constants of the per-size top-k subset table
// Sizes, result codes, the entry record carried by the sorting cells and the
// controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package pstk_pkg;

   localparam int MAX_VARS = 16;
   localparam int NBEST    = 8;
   localparam int RSS_BITS = 32;
   localparam int SLOTS    = MAX_VARS * NBEST;
   localparam int SLOT_W   = 7;
   localparam int CNT_W    = 5;
   localparam int VAR_W    = 4;
   localparam int KEEP_W   = 4;
   localparam int MEM_AW   = SLOT_W + VAR_W;

   localparam logic [RSS_BITS-1:0] RSS_EMPTY = '1;

   typedef enum logic [1:0] {
      REQ_ADD    = 2'd0,
      REQ_RANK   = 2'd1,
      REQ_MEMBER = 2'd2,
      REQ_NONE   = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      ST_BUFFERED = 3'd0,
      ST_INSERTED = 3'd1,
      ST_REJECTED = 3'd2,
      ST_RANKING  = 3'd3,
      ST_MEMBER   = 3'd4,
      ST_INVALID  = 3'd5
   } status_type;

   typedef enum logic {
      CSR_VARS = 1'b0,
      CSR_KEEP = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_CLEAR,
      CELL_INSERT,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      logic                occ;
      logic [RSS_BITS-1:0] rss;
      logic [SLOT_W-1:0]   slot;
      logic [CNT_W-1:0]    cnt;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_BASE,
      S_SCAN,
      S_SETTLE,
      S_COPY,
      S_EMIT,
      S_RANK
   } state_type;

endpackage

`default_nettype wire

@@ hw/rtl/per_size_top_k_subset_table.sv @@
// ----------------------------------------------------------------------------
// per_size_top_k_subset_table: per-size top-k subset table
// Keeps the keep_count smallest residuals per subset size with their members;
// a chain of sorting cells ranks a group as it streams out of the slot RAM.
// ----------------------------------------------------------------------------
// Flow: one item at a time, taken only in idle. A bad request goes straight
//   to its result; an add scans its group, and a complete one that beats the
//   worst entry replaces it, copies its members and scans again; a member read
//   steps to the slot's group and scans it; a ranking scans, lets the chain
//   settle and then shows it. Group scans read the slot RAM one entry per cycle.
// Reset: table empty, no members pending, vars_in_use 16, keep_count 8.
// ----------------------------------------------------------------------------
`default_nettype none

module per_size_top_k_subset_table (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_type,
   input  wire logic [4:0]  req_subset_size,
   input  wire logic [31:0] req_rss,
   input  wire logic [3:0]  req_var_index,
   input  wire logic [6:0]  req_slot,
   input  wire logic [3:0]  req_position,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_bound_rss,
   output logic [31:0]      rsp_entry_rss,
   output logic [6:0]       rsp_entry_slot,
   output logic [4:0]       rsp_member_count,
   output logic [3:0]       rsp_member_value,
   output logic             rsp_last,
   // configuration port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int RW = pstk_pkg::RSS_BITS;
   localparam int SW = pstk_pkg::SLOT_W;
   localparam int CW = pstk_pkg::CNT_W;
   localparam int VW = pstk_pkg::VAR_W;
   localparam int KW = pstk_pkg::KEEP_W;
   localparam int NB = pstk_pkg::NBEST;
   localparam int MV = pstk_pkg::MAX_VARS;

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [CW-1:0] vars_ff, vars_in;
   logic [KW-1:0] keep_ff, keep_in;
   logic          cfg_wr;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;

   // saturate writes into range
   always_comb begin
      vars_in = vars_ff;
      keep_in = keep_ff;
      if (cfg_wr) begin
         unique case (pstk_pkg::csr_index_type'(csr_paddr[2]))
            pstk_pkg::CSR_VARS: begin
               if (csr_pwdata == 32'd0) begin
                  vars_in = CW'(1);
               end else if (csr_pwdata > 32'(MV)) begin
                  vars_in = CW'(MV);
               end else begin
                  vars_in = csr_pwdata[CW-1:0];
               end
            end
            pstk_pkg::CSR_KEEP: begin
               if (csr_pwdata == 32'd0) begin
                  keep_in = KW'(1);
               end else if (csr_pwdata > 32'(NB)) begin
                  keep_in = KW'(NB);
               end else begin
                  keep_in = csr_pwdata[KW-1:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vars_ff <= CW'(MV);
         keep_ff <= KW'(NB);
      end else begin
         vars_ff <= vars_in;
         keep_ff <= keep_in;
      end
   end

   always_comb begin
      unique case (pstk_pkg::csr_index_type'(csr_paddr[2]))
         pstk_pkg::CSR_VARS: csr_prdata = 32'(vars_ff);
         pstk_pkg::CSR_KEEP: csr_prdata = 32'(keep_ff);
         default:            csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------------
   // state
   // ---------------------------------------------------------------------
   pstk_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [SW-1:0]       base_ff, base_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic                rescan_ff, rescan_in;
   logic                complete_ff, complete_in;
   logic [SW-1:0]       ins_slot_ff, ins_slot_in;
   logic [pstk_pkg::SLOTS-1:0] slot_vld_ff, slot_vld_in;
   logic [VW-1:0]       pend_ff [MV];
   logic                pend_we;

   // latched request
   logic [1:0]          op_ff, op_in;
   logic [CW-1:0]       size_ff, size_in;
   logic [RW-1:0]       rss_ff, rss_in;
   logic [SW-1:0]       slot_ff, slot_in;
   logic [VW-1:0]       pos_ff, pos_in;

   // single result registers
   pstk_pkg::status_type ost_ff, ost_in;
   logic [RW-1:0]       obound_ff, obound_in;
   logic [RW-1:0]       oerss_ff, oerss_in;
   logic [SW-1:0]       oslot_ff, oslot_in;
   logic [CW-1:0]       ocnt_ff, ocnt_in;
   logic [VW-1:0]       omval_ff, omval_in;

   // scan tracking
   logic                rd_vld_ff, rd_vld_in;
   logic [SW-1:0]       rd_slot_ff, rd_slot_in;
   logic [RW-1:0]       worst_rss_ff, worst_rss_in;
   logic [SW-1:0]       worst_slot_ff, worst_slot_in;
   logic [RW-1:0]       sel_rss_ff, sel_rss_in;
   logic [CW-1:0]       sel_cnt_ff, sel_cnt_in;

   // memories
   logic                ent_we;
   logic [SW-1:0]       ent_waddr;
   logic [SW-1:0]       ent_raddr;
   logic [CW+RW-1:0]    ent_q;
   logic                mem_we;
   logic [pstk_pkg::MEM_AW-1:0] mem_waddr;
   logic [VW-1:0]       mem_q;

   // chain
   pstk_pkg::cell_op_type cell_op;
   pstk_pkg::entry_type   feed;
   pstk_pkg::entry_type   held [NB];
   pstk_pkg::entry_type   pass [NB];

   // derived request values
   logic [8:0]          grp_prod;
   logic [8:0]          slot_lim;
   logic                size_bad;
   logic                req_acc;
   logic                rsp_acc;
   logic [SW:0]         base_next;

   assign grp_prod  = 9'(req_subset_size - CW'(1)) * 9'(keep_ff);
   assign slot_lim  = 9'(vars_ff) * 9'(keep_ff);
   assign size_bad  = (req_subset_size == '0) || (req_subset_size > vars_ff);
   assign req_acc   = req_valid && req_ready;
   assign rsp_acc   = rsp_valid && rsp_ready;
   assign base_next = (SW + 1)'(base_ff) + (SW + 1)'(keep_ff);

   // ---------------------------------------------------------------------
   // scan data: entry read back from the slot RAM
   // ---------------------------------------------------------------------
   logic [RW-1:0] e_rss;
   logic [CW-1:0] e_cnt;
   logic          e_vld;

   assign e_vld = slot_vld_ff[rd_slot_ff];
   assign e_rss = e_vld ? ent_q[RW-1:0] : pstk_pkg::RSS_EMPTY;
   assign e_cnt = e_vld ? ent_q[CW+RW-1:RW] : '0;

   always_comb begin
      feed.occ  = rd_vld_ff;
      feed.rss  = e_rss;
      feed.slot = rd_slot_ff;
      feed.cnt  = e_cnt;
   end

   // track the lowest slot holding the largest residual, capture the requested slot's entry
   always_comb begin
      worst_rss_in  = worst_rss_ff;
      worst_slot_in = worst_slot_ff;
      sel_rss_in    = sel_rss_ff;
      sel_cnt_in    = sel_cnt_ff;
      if (rd_vld_ff) begin
         if ((rd_slot_ff == base_ff) || (e_rss > worst_rss_ff)) begin
            worst_rss_in  = e_rss;
            worst_slot_in = rd_slot_ff;
         end
         if (rd_slot_ff == slot_ff) begin
            sel_rss_in = e_rss;
            sel_cnt_in = e_cnt;
         end
      end
   end

   // ---------------------------------------------------------------------
   // controller
   // ---------------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      base_in     = base_ff;
      fill_in     = fill_ff;
      rescan_in   = rescan_ff;
      complete_in = complete_ff;
      ins_slot_in = ins_slot_ff;
      slot_vld_in = slot_vld_ff;
      op_in       = op_ff;
      size_in     = size_ff;
      rss_in      = rss_ff;
      slot_in     = slot_ff;
      pos_in      = pos_ff;
      ost_in      = ost_ff;
      obound_in   = obound_ff;
      oerss_in    = oerss_ff;
      oslot_in    = oslot_ff;
      ocnt_in     = ocnt_ff;
      omval_in    = omval_ff;
      rd_vld_in   = 1'b0;
      rd_slot_in  = rd_slot_ff;
      ent_we      = 1'b0;
      ent_waddr   = worst_slot_ff;
      ent_raddr   = rd_slot_ff;
      mem_we      = 1'b0;
      mem_waddr   = {ins_slot_ff, idx_ff[VW-1:0]};
      pend_we     = 1'b0;
      cell_op     = pstk_pkg::CELL_HOLD;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      rsp_status       = ost_ff;
      rsp_bound_rss    = obound_ff;
      rsp_entry_rss    = oerss_ff;
      rsp_entry_slot   = oslot_ff;
      rsp_member_count = ocnt_ff;
      rsp_member_value = omval_ff;
      rsp_last         = 1'b1;

      unique case (state_ff)
         pstk_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_acc) begin
               op_in     = req_type;
               size_in   = req_subset_size;
               rss_in    = req_rss;
               slot_in   = req_slot;
               pos_in    = req_position;
               idx_in    = '0;
               rescan_in = 1'b0;
               cell_op   = pstk_pkg::CELL_CLEAR;
               ost_in    = pstk_pkg::ST_INVALID;
               obound_in = '0;
               oerss_in  = '0;
               oslot_in  = '0;
               ocnt_in   = '0;
               omval_in  = '0;
               state_in  = pstk_pkg::S_EMIT;
               unique case (pstk_pkg::req_code_type'(req_type))
                  pstk_pkg::REQ_ADD: begin
                     if (!size_bad) begin
                        // buffer the member, then scan the group
                        pend_we     = (fill_ff < CW'(MV));
                        complete_in = ((fill_ff + CW'(1)) >= req_subset_size);
                        fill_in     = complete_in ? '0 : (fill_ff + CW'(1));
                        base_in     = grp_prod[SW-1:0];
                        state_in    = pstk_pkg::S_SCAN;
                     end
                  end
                  pstk_pkg::REQ_RANK: begin
                     if (!size_bad) begin
                        base_in  = grp_prod[SW-1:0];
                        state_in = pstk_pkg::S_SCAN;
                     end
                  end
                  pstk_pkg::REQ_MEMBER: begin
                     if (9'(req_slot) < slot_lim) begin
                        base_in  = '0;
                        state_in = pstk_pkg::S_BASE;
                     end
                  end
                  pstk_pkg::REQ_NONE: begin
                  end
                  default: begin
                  end
               endcase
            end
         end

         // step the group base up to the slot one group a cycle
         pstk_pkg::S_BASE: begin
            if (base_next <= (SW + 1)'(slot_ff)) begin
               base_in = base_next[SW-1:0];
            end else begin
               state_in = pstk_pkg::S_SCAN;
            end
         end

         // read the group, one entry a cycle, into the chain
         pstk_pkg::S_SCAN: begin
            cell_op = pstk_pkg::CELL_INSERT;
            if (idx_ff < CW'(keep_ff)) begin
               ent_raddr  = SW'(base_ff + SW'(idx_ff));
               rd_slot_in = ent_raddr;
               rd_vld_in  = 1'b1;
               idx_in     = idx_ff + CW'(1);
            end else if (!rd_vld_ff) begin
               idx_in = '0;
               unique case (pstk_pkg::req_code_type'(op_ff))
                  pstk_pkg::REQ_RANK: begin
                     state_in = pstk_pkg::S_SETTLE;
                  end
                  pstk_pkg::REQ_MEMBER: begin
                     ost_in    = pstk_pkg::ST_MEMBER;
                     obound_in = worst_rss_ff;
                     oerss_in  = sel_rss_ff;
                     oslot_in  = slot_ff;
                     ocnt_in   = sel_cnt_ff;
                     omval_in  = (CW'(pos_ff) < sel_cnt_ff) ? mem_q : '0;
                     state_in  = pstk_pkg::S_EMIT;
                  end
                  default: begin
                     ost_in    = pstk_pkg::ST_BUFFERED;
                     obound_in = worst_rss_ff;
                     oerss_in  = '0;
                     oslot_in  = '0;
                     ocnt_in   = fill_ff;
                     omval_in  = '0;
                     state_in  = pstk_pkg::S_EMIT;
                     if (rescan_ff) begin
                        ost_in   = pstk_pkg::ST_INSERTED;
                        oerss_in = rss_ff;
                        oslot_in = ins_slot_ff;
                        ocnt_in  = size_ff;
                     end else if (complete_ff) begin
                        ocnt_in = size_ff;
                        if (rss_ff < worst_rss_ff) begin
                           // replace the worst entry, then copy members
                           ent_we      = 1'b1;
                           ent_waddr   = worst_slot_ff;
                           slot_vld_in[worst_slot_ff] = 1'b1;
                           ins_slot_in = worst_slot_ff;
                           state_in    = pstk_pkg::S_COPY;
                        end else begin
                           ost_in = pstk_pkg::ST_REJECTED;
                        end
                     end
                  end
               endcase
            end
         end

         // write buffered members into the slot, one a cycle
         pstk_pkg::S_COPY: begin
            mem_we    = 1'b1;
            mem_waddr = {ins_slot_ff, idx_ff[VW-1:0]};
            if (idx_ff == (size_ff - CW'(1))) begin
               idx_in    = '0;
               rescan_in = 1'b1;
               cell_op   = pstk_pkg::CELL_CLEAR;
               state_in  = pstk_pkg::S_SCAN;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end

         // let the last entries ripple down the chain
         pstk_pkg::S_SETTLE: begin
            cell_op = pstk_pkg::CELL_INSERT;
            if (idx_ff == CW'(NB - 1)) begin
               idx_in   = '0;
               state_in = pstk_pkg::S_RANK;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end

         pstk_pkg::S_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_acc) begin
               state_in = pstk_pkg::S_IDLE;
            end
         end

         // present the chain head, shift on each accepted item
         pstk_pkg::S_RANK: begin
            rsp_valid        = 1'b1;
            rsp_status       = pstk_pkg::ST_RANKING;
            rsp_bound_rss    = worst_rss_ff;
            rsp_entry_rss    = held[0].rss;
            rsp_entry_slot   = held[0].slot;
            rsp_member_count = held[0].cnt;
            rsp_member_value = '0;
            rsp_last         = (idx_ff == CW'(keep_ff - KW'(1)));
            if (rsp_acc) begin
               cell_op = pstk_pkg::CELL_SHIFT;
               idx_in  = idx_ff + CW'(1);
               if (rsp_last) begin
                  idx_in   = '0;
                  state_in = pstk_pkg::S_IDLE;
               end
            end
         end

         default: begin
            state_in = pstk_pkg::S_IDLE;
         end
      endcase

      // any register write empties the table and drops pending members
      if (cfg_wr) begin
         slot_vld_in = '0;
         fill_in     = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= pstk_pkg::S_IDLE;
         idx_ff      <= '0;
         fill_ff     <= '0;
         rescan_ff   <= 1'b0;
         complete_ff <= 1'b0;
         slot_vld_ff <= '0;
         rd_vld_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         fill_ff     <= fill_in;
         rescan_ff   <= rescan_in;
         complete_ff <= complete_in;
         slot_vld_ff <= slot_vld_in;
         rd_vld_ff   <= rd_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      base_ff       <= base_in;
      ins_slot_ff   <= ins_slot_in;
      op_ff         <= op_in;
      size_ff       <= size_in;
      rss_ff        <= rss_in;
      slot_ff       <= slot_in;
      pos_ff        <= pos_in;
      ost_ff        <= ost_in;
      obound_ff     <= obound_in;
      oerss_ff      <= oerss_in;
      oslot_ff      <= oslot_in;
      ocnt_ff       <= ocnt_in;
      omval_ff      <= omval_in;
      rd_slot_ff    <= rd_slot_in;
      worst_rss_ff  <= worst_rss_in;
      worst_slot_ff <= worst_slot_in;
      sel_rss_ff    <= sel_rss_in;
      sel_cnt_ff    <= sel_cnt_in;
      if (pend_we) begin
         pend_ff[fill_ff[VW-1:0]] <= req_var_index;
      end
   end

   // ---------------------------------------------------------------------
   // memories
   // ---------------------------------------------------------------------
   pstk_ram #(
      .WIDTH (CW + RW),
      .DEPTH (pstk_pkg::SLOTS)
   ) u_entry_ram (
      .clock (clock),
      .we    (ent_we),
      .waddr (ent_waddr),
      .wdata ({size_ff, rss_ff}),
      .raddr (ent_raddr),
      .rdata (ent_q)
   );

   pstk_ram #(
      .WIDTH (VW),
      .DEPTH (pstk_pkg::SLOTS * MV)
   ) u_member_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (pend_ff[idx_ff[VW-1:0]]),
      .raddr ({slot_ff, pos_ff}),
      .rdata (mem_q)
   );

   // ---------------------------------------------------------------------
   // sorting chain
   // ---------------------------------------------------------------------
   pstk_pkg::entry_type chain_end;
   assign chain_end = '0;

   for (genvar gi = 0; gi < NB; gi++) begin : g_cell
      pstk_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (cell_op),
         .left_in    ((gi == 0) ? feed : pass[(gi == 0) ? 0 : gi - 1]),
         .right_held ((gi == NB - 1) ? chain_end : held[(gi == NB - 1) ? gi : gi + 1]),
         .pass_out   (pass[gi]),
         .held_out   (held[gi])
      );
   end

`ifndef ASSERT_OFF
   // the chain head holds an entry whenever a ranking item is shown
   a_rank_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pstk_pkg::S_RANK) |-> held[0].occ)
      else $error("ranking shown from an empty chain");

   // the first two chain entries are in order while ranking
   a_rank_sorted: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == pstk_pkg::S_RANK) && held[1 % NB].occ && (NB > 1))
         |-> (held[0].rss <= held[1 % NB].rss))
      else $error("chain out of order");

   // no new item is taken while a result is shown
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("item taken while result pending");

   // an inserting add has cleared the member buffer when its result is shown
   a_fill_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == pstk_pkg::ST_INSERTED)) |-> (fill_ff == '0))
      else $error("member buffer not cleared after insert");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/pstk_ram.sv @@
// ----------------------------------------------------------------------------
// pstk_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pstk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

@@ hw/rtl/pstk_cell.sv @@
// ----------------------------------------------------------------------------
// pstk_cell: one cell of the systolic sorting chain
// Keeps the smallest entry it has seen and hands larger ones to the right;
// in shift mode it takes the entry of its right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module pstk_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pstk_pkg::cell_op_type op,
   input  wire pstk_pkg::entry_type   left_in,
   input  wire pstk_pkg::entry_type   right_held,
   output pstk_pkg::entry_type        pass_out,
   output pstk_pkg::entry_type        held_out
);

   pstk_pkg::entry_type held_ff, held_in;
   pstk_pkg::entry_type pass_ff, pass_in;
   logic                take;

   // keep the incoming entry when it orders first by residual, then by slot,
   // or when the cell is empty
   assign take = left_in.occ && (!held_ff.occ || (left_in.rss < held_ff.rss) ||
                                 ((left_in.rss == held_ff.rss) &&
                                  (left_in.slot < held_ff.slot)));

   always_comb begin
      held_in = held_ff;
      pass_in = pass_ff;
      unique case (op)
         pstk_pkg::CELL_HOLD: begin
         end
         pstk_pkg::CELL_CLEAR: begin
            held_in.occ = 1'b0;
            pass_in.occ = 1'b0;
         end
         pstk_pkg::CELL_INSERT: begin
            if (take) begin
               held_in = left_in;
               pass_in = held_ff;
            end else begin
               pass_in = left_in;
            end
         end
         pstk_pkg::CELL_SHIFT: begin
            held_in     = right_held;
            pass_in.occ = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         pass_ff <= '0;
      end else begin
         held_ff <= held_in;
         pass_ff <= pass_in;
      end
   end

   assign pass_out = pass_ff;
   assign held_out = held_ff;

endmodule

`default_nettype wire

@@ sim/tb_per_size_top_k_subset_table.sv @@
// ----------------------------------------------------------------------------
// tb_per_size_top_k_subset_table: self-checking bench of the subset table
// Streams add, ranking and member-read items through the request channel,
// predicts every result from a local copy of the table and checks each result
// in order, stalling both sides at random except in the last part.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_per_size_top_k_subset_table;

   typedef struct {
      logic [1:0]  kind;
      logic [4:0]  size;
      logic [31:0] rss;
      logic [3:0]  var_idx;
      logic [6:0]  slot;
      logic [3:0]  pos;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] bound;
      logic [31:0] erss;
      logic [6:0]  eslot;
      logic [4:0]  cnt;
      logic [3:0]  mval;
      logic        last;
   } rsp_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type = '0;
   logic [4:0]  req_subset_size = '0;
   logic [31:0] req_rss = '0;
   logic [3:0]  req_var_index = '0;
   logic [6:0]  req_slot = '0;
   logic [3:0]  req_position = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_bound_rss;
   logic [31:0] rsp_entry_rss;
   logic [6:0]  rsp_entry_slot;
   logic [4:0]  rsp_member_count;
   logic [3:0]  rsp_member_value;
   logic        rsp_last;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   per_size_top_k_subset_table u_top (.*);

   // 10-unit clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // local copy of the table
   logic [31:0] tab_rss [pstk_pkg::SLOTS];
   logic [4:0]  tab_cnt [pstk_pkg::SLOTS];
   logic [3:0]  tab_mem [pstk_pkg::SLOTS][pstk_pkg::MAX_VARS];
   logic [3:0]  pend_mem [pstk_pkg::MAX_VARS];
   int unsigned pend_fill;
   int unsigned vars_cfg = pstk_pkg::MAX_VARS;
   int unsigned keep_cfg = pstk_pkg::NBEST;

   req_item_type stim_q[$];
   rsp_item_type want_q[$];
   req_item_type req_cur;
   int           req_gap = 0;
   int           rsp_gap = 0;
   int           errors = 0;
   bit           quiet = 1'b0;

   task automatic report(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   function automatic void clear_table();
      for (int i = 0; i < pstk_pkg::SLOTS; i++) begin
         tab_rss[i] = pstk_pkg::RSS_EMPTY;
         tab_cnt[i] = '0;
      end
      pend_fill = 0;
   endfunction

   function automatic int unsigned worst_of(int unsigned base);
      int unsigned w;
      w = base;
      for (int k = 1; k < keep_cfg; k++)
         if (tab_rss[base + k] > tab_rss[w]) w = base + k;
      return w;
   endfunction

   function automatic void want(pstk_pkg::status_type st, logic [31:0] bound,
                                logic [31:0] erss, int unsigned eslot, int unsigned cnt,
                                logic [3:0] mval, logic last);
      rsp_item_type r;
      r = '{st, bound, erss, eslot[6:0], cnt[4:0], mval, last};
      want_q.push_back(r);
   endfunction

   // predict the results of one accepted item and update the table
   function automatic void table_step(req_item_type it);
      int unsigned base, w, t, best;
      int unsigned order [pstk_pkg::NBEST];
      logic [31:0] bound;
      logic [3:0]  mval;
      if (it.kind == pstk_pkg::REQ_ADD || it.kind == pstk_pkg::REQ_RANK) begin
         if (it.size == 0 || it.size > vars_cfg) begin
            want(pstk_pkg::ST_INVALID, 0, 0, 0, 0, 0, 1'b1);
            return;
         end
         base = (it.size - 1) * keep_cfg;
         if (it.kind == pstk_pkg::REQ_ADD) begin
            if (pend_fill < pstk_pkg::MAX_VARS) pend_mem[pend_fill] = it.var_idx;
            if (pend_fill + 1 >= it.size) begin
               pend_fill = 0;
               w = worst_of(base);
               if (it.rss < tab_rss[w]) begin
                  tab_rss[w] = it.rss;
                  tab_cnt[w] = it.size;
                  for (int i = 0; i < it.size; i++) tab_mem[w][i] = pend_mem[i];
                  want(pstk_pkg::ST_INSERTED, tab_rss[worst_of(base)], it.rss, w, it.size,
                       0, 1'b1);
               end else begin
                  want(pstk_pkg::ST_REJECTED, tab_rss[w], 0, 0, it.size, 0, 1'b1);
               end
            end else begin
               pend_fill++;
               want(pstk_pkg::ST_BUFFERED, tab_rss[worst_of(base)], 0, 0, pend_fill, 0,
                    1'b1);
            end
         end else begin
            bound = tab_rss[worst_of(base)];
            for (int i = 0; i < keep_cfg; i++) order[i] = base + i;
            // selection sort on (residual, slot)
            for (int i = 0; i < keep_cfg; i++) begin
               best = i;
               for (int j = i + 1; j < keep_cfg; j++)
                  if (tab_rss[order[j]] < tab_rss[order[best]] ||
                      (tab_rss[order[j]] == tab_rss[order[best]] &&
                       order[j] < order[best])) best = j;
               t = order[i];
               order[i] = order[best];
               order[best] = t;
               want(pstk_pkg::ST_RANKING, bound, tab_rss[order[i]], order[i],
                    tab_cnt[order[i]], 0, i + 1 == keep_cfg);
            end
         end
      end else if (it.kind == pstk_pkg::REQ_MEMBER && it.slot < vars_cfg * keep_cfg) begin
         base = (it.slot / keep_cfg) * keep_cfg;
         mval = (it.pos < tab_cnt[it.slot]) ? tab_mem[it.slot][it.pos] : 4'd0;
         want(pstk_pkg::ST_MEMBER, tab_rss[worst_of(base)], tab_rss[it.slot], it.slot,
              tab_cnt[it.slot], mval, 1'b1);
      end else begin
         want(pstk_pkg::ST_INVALID, 0, 0, 0, 0, 0, 1'b1);
      end
   endfunction

   // driver: hold an offered item until taken, then advance or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) table_step(req_cur);
         if (!req_valid || req_ready) begin
            if (!quiet && req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (!quiet && $urandom_range(3) == 0) begin
               req_gap = $urandom_range(3);
               req_valid <= 1'b0;
            end else if (stim_q.size() > 0) begin
               req_cur = stim_q.pop_front();
               req_type <= req_cur.kind;
               req_subset_size <= req_cur.size;
               req_rss <= req_cur.rss;
               req_var_index <= req_cur.var_idx;
               req_slot <= req_cur.slot;
               req_position <= req_cur.pos;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each taken result against the oldest prediction
   always @(posedge clock) begin
      rsp_item_type got, exp_r;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_status, rsp_bound_rss, rsp_entry_rss, rsp_entry_slot,
                    rsp_member_count, rsp_member_value, rsp_last};
            if (want_q.size() == 0) begin
               report($sformatf("unexpected result %p", got));
            end else begin
               exp_r = want_q.pop_front();
               if (got !== exp_r) report($sformatf("got %p want %p", got, exp_r));
            end
         end
         if (quiet) begin
            rsp_ready <= 1'b1;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(3) == 0) begin
            rsp_gap = $urandom_range(3);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic push_item(logic [1:0] kind, int unsigned size, logic [31:0] rss,
                            int unsigned vi, int unsigned slot, int unsigned pos);
      req_item_type it;
      it = '{kind, size[4:0], rss, vi[3:0], slot[6:0], pos[3:0]};
      stim_q.push_back(it);
   endtask

   // wait until every item is taken and answered, then let the block settle
   task automatic drain();
      @(posedge clock);
      #1;
      while (stim_q.size() != 0 || req_valid || want_q.size() != 0) begin
         @(posedge clock);
         #1;
      end
      repeat (60) @(posedge clock);
   endtask

   task automatic csr_write(pstk_pkg::csr_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 3'(4 * idx);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == pstk_pkg::CSR_VARS)
         vars_cfg = (value == 0) ? 1 :
                    (value > pstk_pkg::MAX_VARS) ? pstk_pkg::MAX_VARS : value;
      else
         keep_cfg = (value == 0) ? 1 : (value > pstk_pkg::NBEST) ? pstk_pkg::NBEST : value;
      clear_table();
   endtask

   function automatic logic [31:0] pick_rss();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 5) return pstk_pkg::RSS_EMPTY;
      if (r < 55) return $urandom_range(20);
      return $urandom();
   endfunction

   // random items: mostly complete subsets, then reads, then noise
   task automatic random_items(int n);
      int unsigned r, sz, top;
      logic [31:0] v;
      int made;
      made = 0;
      while (made < n) begin
         r = $urandom_range(99);
         if (r < 55) begin
            top = (vars_cfg < 4) ? vars_cfg : 4;
            sz = ($urandom_range(9) == 0) ? vars_cfg : $urandom_range(1, top);
            v = pick_rss();
            for (int i = 1; i <= sz; i++)
               push_item(pstk_pkg::REQ_ADD, sz, (i == sz) ? v : $urandom(),
                         $urandom_range(15), $urandom_range(127), $urandom_range(15));
            made += sz;
         end else if (r < 70) begin
            push_item(pstk_pkg::REQ_RANK, $urandom_range(1, vars_cfg), $urandom(),
                      $urandom_range(15), $urandom_range(127), $urandom_range(15));
            made++;
         end else if (r < 88) begin
            push_item(pstk_pkg::REQ_MEMBER, $urandom_range(31), $urandom(),
                      $urandom_range(15), $urandom_range(vars_cfg * keep_cfg - 1),
                      $urandom_range(15));
            made++;
         end else begin
            // noise: any type, size, slot and a size change in mid-stream
            push_item(2'($urandom_range(3)), $urandom_range(31), $urandom(),
                      $urandom_range(15), $urandom_range(127), $urandom_range(15));
            made++;
         end
      end
   endtask

   initial begin
      clear_table();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: reset defaults
      push_item(pstk_pkg::REQ_RANK, 1, 0, 0, 0, 0);
      push_item(pstk_pkg::REQ_ADD, 1, 32'd0, 15, 0, 0);
      push_item(pstk_pkg::REQ_ADD, 1, pstk_pkg::RSS_EMPTY, 3, 0, 0);
      push_item(pstk_pkg::REQ_ADD, 1, 32'hFFFF_FFFE, 0, 0, 0);
      push_item(pstk_pkg::REQ_ADD, 2, 32'd7, 5, 0, 0);
      push_item(pstk_pkg::REQ_ADD, 2, 32'd7, 9, 0, 0);
      push_item(pstk_pkg::REQ_ADD, 2, 32'd7, 1, 0, 0);
      push_item(pstk_pkg::REQ_ADD, 2, 32'd7, 2, 0, 0);
      push_item(pstk_pkg::REQ_ADD, 3, 32'd100, 4, 0, 0);
      push_item(pstk_pkg::REQ_ADD, 3, 32'd100, 6, 0, 0);
      push_item(pstk_pkg::REQ_ADD, 1, 32'd50, 8, 0, 0);   // size shrinks in mid-stream
      push_item(pstk_pkg::REQ_ADD, 16, 32'd1, 15, 0, 0);
      push_item(pstk_pkg::REQ_RANK, 1, 0, 0, 0, 0);
      push_item(pstk_pkg::REQ_RANK, 2, 0, 0, 0, 0);
      push_item(pstk_pkg::REQ_RANK, 16, 0, 0, 0, 0);
      push_item(pstk_pkg::REQ_MEMBER, 0, 0, 0, 0, 0);
      push_item(pstk_pkg::REQ_MEMBER, 0, 0, 0, 8, 1);
      push_item(pstk_pkg::REQ_MEMBER, 0, 0, 0, 0, 15);     // position past the members
      push_item(pstk_pkg::REQ_MEMBER, 0, 0, 0, 127, 0);
      push_item(pstk_pkg::REQ_ADD, 0, 32'd3, 0, 0, 0);     // bad sizes
      push_item(pstk_pkg::REQ_RANK, 17, 0, 0, 0, 0);
      push_item(pstk_pkg::REQ_ADD, 31, 32'd3, 0, 0, 0);
      push_item(pstk_pkg::REQ_NONE, 1, 0, 0, 0, 0);
      random_items(30);
      drain();

      // smallest settings, then out-of-range writes that saturate
      csr_write(pstk_pkg::CSR_VARS, 1);
      csr_write(pstk_pkg::CSR_KEEP, 1);
      random_items(20);
      drain();
      csr_write(pstk_pkg::CSR_VARS, 0);
      csr_write(pstk_pkg::CSR_KEEP, 0);
      random_items(10);
      drain();
      csr_write(pstk_pkg::CSR_VARS, 31);
      csr_write(pstk_pkg::CSR_KEEP, 15);
      random_items(30);
      drain();
      csr_write(pstk_pkg::CSR_VARS, 5);
      csr_write(pstk_pkg::CSR_KEEP, 3);
      random_items(30);
      drain();

      // last part without idling
      csr_write(pstk_pkg::CSR_VARS, 16);
      csr_write(pstk_pkg::CSR_KEEP, 8);
      quiet = 1'b1;
      random_items(30);
      drain();

      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #3000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

`default_nettype wire

@@ per_size_top_k_subset_table.f @@
hw/rtl/pstk_pkg.sv
hw/rtl/pstk_ram.sv
hw/rtl/pstk_cell.sv
hw/rtl/per_size_top_k_subset_table.sv
sim/tb_per_size_top_k_subset_table.sv
